// ----- hw/rtl/crc32rp_pkg.sv -----
// Shared constants and helpers for the programmable-polynomial reflected CRC-32 unit.
package crc32rp_pkg;

    localparam int unsigned CrcWidth  = 32;
    localparam int unsigned ByteWidth = 8;

    localparam logic [CrcWidth-1:0] CrcPreset = 32'hFFFF_FFFF;
    localparam logic [CrcWidth-1:0] PolyReset = 32'h04C1_1DB7;

    typedef logic [CrcWidth-1:0]  crc_t;
    typedef logic [ByteWidth-1:0] byte_t;

    // Mirror bit order: normal polynomial form into reflected form.
    function automatic crc_t reverse_bits(input crc_t v);
        crc_t r;
        for (int i = 0; i < CrcWidth; i++)
        begin
            r[i] = v[CrcWidth-1-i];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/crc32_reflected_programmable_poly_unit.sv -----
// Top level of the byte-serial reflected CRC-32 unit with programmable polynomial.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | data_byte[7:0], first_byte, last_byte
//  out     | out_valid / out_stall| crc_value[31:0]
//  cfg     | cfg_we               | cfg_data[31:0] (polynomial, normal order)
//
// One byte per clock sustained while in_stall is low: a request is accepted into the input register,
// and the eight-step fold updates the CRC register when that byte advances out of it.
// A result enters the output register at that same edge, as its last byte advances.
// Reset presets the CRC to all ones and the polynomial to 0x04C11DB7.
// A stalled, full output holds back only a last byte in the input register,
// which then stalls the input; other bytes keep folding.
module crc32_reflected_programmable_poly_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  crc32rp_pkg::byte_t data_byte,
    input  logic               first_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output crc32rp_pkg::crc_t  crc_value,
    input  logic               cfg_we,
    input  crc32rp_pkg::crc_t  cfg_data
);
    import crc32rp_pkg::*;

    crc_t  poly_reg;
    crc_t  crc_reg;
    crc_t  crc_next;
    crc_t  fold_base;
    logic  s1_valid_reg;
    logic  s1_valid_next;
    byte_t s1_data_reg;
    logic  s1_first_reg;
    logic  s1_last_reg;
    logic  s1_adv;
    logic  in_take;
    logic  out_valid_reg;
    logic  out_valid_next;
    crc_t  out_crc_reg;

    // Advance the held byte unless it would emit into a full, stalled output.
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_adv);
    assign out_valid_next = (s1_adv && s1_last_reg) || (out_valid_reg && out_stall);

    assign fold_base = s1_first_reg ? CrcPreset : crc_reg;

    crc32rp_fold u_fold (
        .crc_in  (fold_base),
        .data_in (s1_data_reg),
        .rpoly   (reverse_bits(poly_reg)),
        .crc_out (crc_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= PolyReset;
            crc_reg       <= CrcPreset;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                poly_reg <= cfg_data;
            end
            if (s1_adv)
            begin
                crc_reg <= crc_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg  <= data_byte;
            s1_first_reg <= first_byte;
            s1_last_reg  <= last_byte;
        end
        if (s1_adv && s1_last_reg)
        begin
            out_crc_reg <= crc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign crc_value = out_crc_reg;

    a_no_stall_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_hold_blocked_byte : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_data_reg)
            && $stable(crc_reg))
        else $error("blocked byte or CRC changed");

    a_last_emits : assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_last_reg |=> out_valid_reg && (out_crc_reg == crc_reg))
        else $error("last byte did not produce matching result");

    a_block_only_on_full_out : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_last_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

endmodule

// ----- hw/rtl/crc32rp_fold.sv -----
// Eight unrolled LSB-first shift/xor steps that fold one byte into the CRC.
module crc32rp_fold (
    input  crc32rp_pkg::crc_t  crc_in,
    input  crc32rp_pkg::byte_t data_in,
    input  crc32rp_pkg::crc_t  rpoly,
    output crc32rp_pkg::crc_t  crc_out
);
    import crc32rp_pkg::*;

    crc_t acc;

    always_comb
    begin
        acc = crc_in ^ {{(CrcWidth-ByteWidth){1'b0}}, data_in};
        for (int k = 0; k < ByteWidth; k++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ rpoly;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        crc_out = acc;
    end

endmodule

// ----- dv/crc32_reflected_programmable_poly_unit_tb.sv -----
// Self-checking testbench for the byte-serial reflected CRC-32 unit with programmable polynomial.
`timescale 1ns / 100ps

module crc32_reflected_programmable_poly_unit_tb;
    import crc32rp_pkg::*;

    typedef struct packed {
        byte_t data;
        logic  first;
        logic  last;
    } crc_req_t;

    typedef enum int unsigned {
        RxFree,
        RxLight,
        RxHeavy,
        RxToggle
    } rx_mode_e;

    localparam int unsigned DrainCycles    = 8;
    localparam int unsigned LongHoldCycles = 300;
    localparam int unsigned PhaseItems     = 250;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  in_valid   = 1'b0;
    logic  in_stall;
    byte_t data_byte  = '0;
    logic  first_byte = 1'b0;
    logic  last_byte  = 1'b0;
    logic  out_valid;
    logic  out_stall  = 1'b0;
    crc_t  crc_value;
    logic  cfg_we     = 1'b0;
    crc_t  cfg_data   = '0;

    crc_req_t    req_q[$];
    crc_t        crc_expected_q[$];
    crc_t        model_crc   = CrcPreset;
    crc_t        model_poly  = PolyReset;
    int unsigned reqs_queued = 0;
    int unsigned reqs_taken  = 0;
    int unsigned hold_asked  = 0;
    int unsigned n_errors    = 0;
    logic        req_fired   = 1'b0;

    int unsigned burst_left   = 0;
    int unsigned gap_left     = 0;
    rx_mode_e    rx_mode      = RxFree;
    int unsigned rx_mode_left = 0;
    int unsigned hold_left    = 0;
    int unsigned hold_seen    = 0;

    always #1 clk = ~clk;

    crc32_reflected_programmable_poly_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .crc_value  (crc_value),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    // Fold one byte LSB-first through the reflected form of a normal-order polynomial.
    function automatic crc_t fold_crc(crc_t crc, byte_t b, crc_t poly);
        crc_t rpoly;
        crc_t c;
        for (int i = 0; i < 32; i++)
        begin
            rpoly[i] = poly[31-i];
        end
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
        end
        return c;
    endfunction

    // Check results first, then advance the CRC model on an accepted request.
    always @(posedge clk)
    begin
        req_fired <= in_valid && (in_stall === 1'b0);
        if (rst_n)
        begin
            if (out_valid === 1'b1 && !out_stall)
            begin
                if (crc_expected_q.size() == 0)
                begin
                    $error("crc_value: result with none expected, actual %h", crc_value);
                    n_errors++;
                end
                else
                begin
                    if (crc_value !== crc_expected_q[0])
                    begin
                        $error("crc_value mismatch: expected %h, actual %h",
                               crc_expected_q[0], crc_value);
                        n_errors++;
                    end
                    void'(crc_expected_q.pop_front());
                end
            end
            if (in_valid && in_stall === 1'b0)
            begin
                if (first_byte)
                    model_crc = CrcPreset;
                model_crc = fold_crc(model_crc, data_byte, model_poly);
                if (last_byte)
                    crc_expected_q.push_back(model_crc);
                reqs_taken++;
            end
        end
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        crc_req_t nxt;
        logic     hold;
        hold = in_valid && !req_fired;
        if (rst_n && !hold)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (req_q.size() > 0)
            begin
                nxt = req_q.pop_front();
                in_valid   <= 1'b1;
                data_byte  <= nxt.data;
                first_byte <= nxt.first;
                last_byte  <= nxt.last;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: stall pattern switches to a random mode after each run of random length.
    always @(negedge clk)
    begin
        logic stall;
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = LongHoldCycles;
        end
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_e'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(8, 80);
        end
        else
            rx_mode_left--;
        case (rx_mode)
            RxFree:  stall = 1'b0;
            RxLight: stall = ($urandom_range(0, 3) == 0);
            RxHeavy: stall = ($urandom_range(0, 3) != 0);
            default: stall = rx_mode_left[0];
        endcase
        if (hold_left > 0)
        begin
            hold_left--;
            stall = 1'b1;
        end
        out_stall <= stall;
    end

    task automatic add_req(byte_t d, logic f, logic l);
        req_q.push_back(crc_req_t'{data: d, first: f, last: l});
        reqs_queued++;
    endtask

    task automatic add_message(int unsigned len);
        for (int unsigned i = 0; i < len; i++)
        begin
            add_req(byte_t'($urandom), i == 0, i == len - 1);
        end
    endtask

    // Mostly well-formed messages, with some loose bytes and messages missing a start or an end.
    task automatic add_random_traffic(int unsigned n_items);
        int unsigned start;
        int unsigned len;
        logic        f_ok;
        logic        l_ok;
        start = reqs_queued;
        while (reqs_queued - start < n_items)
        begin
            case ($urandom_range(0, 9))
                0: add_req(byte_t'($urandom), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
                1:
                begin
                    len  = $urandom_range(1, 8);
                    f_ok = 1'($urandom_range(0, 1));
                    l_ok = 1'($urandom_range(0, 1));
                    for (int unsigned i = 0; i < len; i++)
                    begin
                        add_req(byte_t'($urandom), f_ok && i == 0, l_ok && i == len - 1);
                    end
                end
                9: add_message($urandom_range(1, 64));
                default: add_message($urandom_range(1, 10));
            endcase
        end
    endtask

    // Hold until every request is taken and every result is back, then let the pipe drain.
    task automatic wait_idle();
        @(negedge clk);
        while (reqs_taken != reqs_queued || crc_expected_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_poly(crc_t v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we     <= 1'b0;
        model_poly = v;
        @(posedge clk);
    endtask

    initial
    begin
        crc_t poly_set[8];
        poly_set = '{PolyReset, 32'h0000_0001, 32'h8000_0000, 32'h0,
                     32'h1EDC_6F41, 32'h0, 32'hFFFF_FFFF, 32'h0000_0000};
        poly_set[3] = $urandom;
        poly_set[5] = $urandom;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Loose byte straight after reset, one-byte messages, then a continuation.
        add_req(8'hA5, 1'b0, 1'b1);
        add_req(8'h00, 1'b1, 1'b1);
        add_req(8'hFF, 1'b1, 1'b1);
        add_req(8'h3C, 1'b0, 1'b0);
        add_req(8'h55, 1'b0, 1'b1);
        for (int i = 0; i < 9; i++)
        begin
            add_req(byte_t'(8'h31 + i), i == 0, i == 8);
        end
        // Leave a message open across a polynomial change.
        add_req(8'hAA, 1'b1, 1'b0);
        add_req(8'h0F, 1'b0, 1'b0);
        wait_idle();
        write_poly(32'h0000_0000);
        add_req(8'hF0, 1'b0, 1'b0);
        add_req(8'h81, 1'b0, 1'b1);
        add_req(8'hFF, 1'b1, 1'b1);
        wait_idle();
        write_poly(32'hFFFF_FFFF);
        add_req(8'h00, 1'b1, 1'b0);
        add_req(8'hFF, 1'b0, 1'b1);
        add_req(8'h80, 1'b1, 1'b1);

        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            write_poly(poly_set[p]);
            // Stall the output for a long stretch while requests keep coming.
            if (p == 2)
                hold_asked++;
            add_random_traffic(PhaseItems);
        end
        wait_idle();

        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
